@@ hdl/wdt_pkg.sv @@
// Shared constants, codes and handshake structs for the word dictionary tokenizer.
package wdt_pkg;

  localparam int DICT_DEPTH_DEF = 1024;
  localparam int WORD_BYTES_DEF = 32;
  localparam int OUT_W = 11;

  localparam logic [1:0] OP_LEARN     = 2'd0;
  localparam logic [1:0] OP_TRANSLATE = 2'd1;
  localparam logic [1:0] OP_QUERY     = 2'd2;
  localparam logic [1:0] OP_CLEAR     = 2'd3;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PERIOD  = 8'h2E;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  localparam logic KIND_TOKEN = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  typedef struct packed {
    logic accept;   // item taken this cycle
    logic rd_en;    // read one dictionary entry
    logic finish;   // commit learn or emit token
  } wdt_cmd_t;

  typedef struct packed {
    logic sep;      // input byte is a separator
    logic word_nz;  // pending word is not empty
  } wdt_sts_t;

endpackage

@@ hdl/wdt_ctrl.sv @@
// Controller: sequences the dictionary scan when a word ends.
module wdt_ctrl #(
  parameter int DICT_DEPTH = wdt_pkg::DICT_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [1:0]                         opcode,
  input  wdt_pkg::wdt_sts_t                  sts,
  input  logic [$clog2(DICT_DEPTH+1)-1:0]    total,
  output logic                               busy,
  output logic [$clog2(DICT_DEPTH)-1:0]      rd_addr,
  output wdt_pkg::wdt_cmd_t                  cmd
);
  localparam int AW = $clog2(DICT_DEPTH);
  localparam int CW = $clog2(DICT_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic          last;

  assign busy    = (state_r != S_IDLE);
  assign rd_addr = addr_r;
  assign last    = ((CW'(addr_r) + CW'(1)) == total);

  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          addr_nxt   = '0;
          if (!opcode[1] && sts.sep && sts.word_nz) begin
            state_nxt = (total == '0) ? S_FIN : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        addr_nxt  = addr_r + AW'(1);
        if (last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      addr_r  <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
    end
  end
endmodule

@@ hdl/wdt_datapath.sv @@
// Datapath: word buffer, dictionary memory, rank compare and result registers.
module wdt_datapath #(
  parameter int DICT_DEPTH = wdt_pkg::DICT_DEPTH_DEF,
  parameter int WORD_BYTES = wdt_pkg::WORD_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  wdt_pkg::wdt_cmd_t                  cmd,
  input  logic [1:0]                         opcode,
  input  logic [7:0]                         char_byte,
  input  logic [$clog2(DICT_DEPTH)-1:0]      rd_addr,
  output wdt_pkg::wdt_sts_t                  sts,
  output logic [$clog2(DICT_DEPTH+1)-1:0]    total,
  output logic                               out_valid,
  output logic                               out_result_kind,
  output logic [wdt_pkg::OUT_W-1:0]          out_token_index,
  output logic                               out_found,
  output logic                               out_separator_kind,
  output logic [wdt_pkg::OUT_W-1:0]          out_word_count,
  output logic                               out_dict_full
);
  localparam int AW = $clog2(DICT_DEPTH);
  localparam int CW = $clog2(DICT_DEPTH + 1);
  localparam int BW = $clog2(WORD_BYTES);
  localparam int LW = $clog2(WORD_BYTES + 1);
  localparam int RW = LW + WORD_BYTES * 8;
  localparam int OW = wdt_pkg::OUT_W;

  logic [7:0]    word_r [WORD_BYTES];
  logic [LW-1:0] len_r;
  logic [CW-1:0] total_r;
  logic          full_r;
  logic [1:0]    op_r;
  logic          period_r;
  logic [RW-1:0] dict_mem [DICT_DEPTH];
  logic [RW-1:0] rd_data_r;
  logic          rd_vld_r;
  logic [CW-1:0] less_r;
  logic          hit_r;
  logic [RW-1:0] wr_row;

  logic          ov_r, okind_r, ofound_r, osep_r, ofull_r;
  logic [OW-1:0] otok_r, ocnt_r;

  logic          sep;
  logic [LW-1:0] el, n;
  logic          diff, lt_b, ent_lt, ent_eq;
  logic [7:0]    a;

  assign sep = (char_byte == wdt_pkg::CH_SPACE) || (char_byte == wdt_pkg::CH_PERIOD) ||
               (char_byte == wdt_pkg::CH_NEWLINE);
  assign sts.sep     = sep;
  assign sts.word_nz = (len_r != '0);
  assign total       = total_r;

  always_comb begin
    for (int i = 0; i < WORD_BYTES; i++) begin
      wr_row[i*8 +: 8] = word_r[i];
    end
    wr_row[RW-1 -: LW] = len_r;
  end

  // Rank compare: first differing byte within the common length, then length.
  always_comb begin
    el   = rd_data_r[RW-1 -: LW];
    n    = (el < len_r) ? el : len_r;
    diff = 1'b0;
    lt_b = 1'b0;
    a    = '0;
    for (int i = WORD_BYTES - 1; i >= 0; i--) begin
      a = rd_data_r[i*8 +: 8];
      if ((LW'(i) < n) && (a != word_r[i])) begin
        diff = 1'b1;
        lt_b = (a < word_r[i]);
      end
    end
    ent_eq = !diff && (el == len_r);
    ent_lt = diff ? lt_b : (el < len_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= dict_mem[rd_addr];
    end
    if (cmd.finish && (op_r == wdt_pkg::OP_LEARN) && !hit_r &&
        (total_r < CW'(DICT_DEPTH))) begin
      dict_mem[total_r[AW-1:0]] <= wr_row;
    end
    if (cmd.accept && !opcode[1] && !sep && (len_r < LW'(WORD_BYTES))) begin
      word_r[len_r[BW-1:0]] <= char_byte;
    end
    if (cmd.accept) begin
      op_r     <= opcode;
      period_r <= (char_byte == wdt_pkg::CH_PERIOD);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      total_r  <= '0;
      full_r   <= 1'b0;
      rd_vld_r <= 1'b0;
      less_r   <= '0;
      hit_r    <= 1'b0;
      ov_r     <= 1'b0;
      okind_r  <= 1'b0;
      otok_r   <= '0;
      ofound_r <= 1'b0;
      osep_r   <= 1'b0;
      ocnt_r   <= '0;
      ofull_r  <= 1'b0;
    end else begin
      rd_vld_r <= cmd.rd_en;
      ov_r     <= 1'b0;
      if (rd_vld_r) begin
        if (ent_eq) begin
          hit_r <= 1'b1;
        end else if (ent_lt) begin
          less_r <= less_r + CW'(1);
        end
      end
      if (cmd.accept) begin
        less_r <= '0;
        hit_r  <= 1'b0;
        case (opcode)
          wdt_pkg::OP_QUERY: begin
            ov_r     <= 1'b1;
            okind_r  <= wdt_pkg::KIND_COUNT;
            otok_r   <= '0;
            ofound_r <= 1'b0;
            osep_r   <= 1'b0;
            ocnt_r   <= OW'(total_r);
            ofull_r  <= full_r;
          end
          wdt_pkg::OP_CLEAR: begin
            total_r <= '0;
            len_r   <= '0;
            full_r  <= 1'b0;
          end
          default: begin
            if (!sep && (len_r < LW'(WORD_BYTES))) begin
              len_r <= len_r + LW'(1);
            end
          end
        endcase
      end
      if (cmd.finish) begin
        len_r <= '0;
        if (op_r == wdt_pkg::OP_LEARN) begin
          if (!hit_r) begin
            if (total_r < CW'(DICT_DEPTH)) begin
              total_r <= total_r + CW'(1);
            end else begin
              full_r <= 1'b1;
            end
          end
        end else begin
          ov_r     <= 1'b1;
          okind_r  <= wdt_pkg::KIND_TOKEN;
          otok_r   <= hit_r ? OW'(less_r + CW'(1)) : '0;
          ofound_r <= hit_r;
          osep_r   <= period_r;
          ocnt_r   <= '0;
          ofull_r  <= 1'b0;
        end
      end
    end
  end

  assign out_valid          = ov_r;
  assign out_result_kind    = okind_r;
  assign out_token_index    = otok_r;
  assign out_found          = ofound_r;
  assign out_separator_kind = osep_r;
  assign out_word_count     = ocnt_r;
  assign out_dict_full      = ofull_r;
endmodule

@@ hdl/word_dictionary_tokenizer_core.sv @@
// Top level of the word dictionary tokenizer: controller plus datapath.
// Usage:
//   Input channel: drive in_opcode and in_char_byte with start high; the word
//   is taken at a rising edge where start is high and busy is low.
//   Result channel: out_valid strobes for one cycle with the result word on
//   the out_ ports; the receiver must take it then, it cannot stall the block.
// Timing:
//   Text bytes that extend a word, separators with no pending word, clear
//   and query are taken with busy staying low. A query result appears the
//   cycle after it is taken.
//   A separator ending a non-empty word in learn or translate mode holds busy
//   through the scan, drain and finish states, scanning each stored word once
//   (only the finish state when the store is empty). One dictionary row is
//   read from the single-port entry memory per cycle and compared against
//   the whole word; that scan sets the rate. A token result strobes in the
//   first cycle with busy low again.
// Reset:
//   Synchronous active-low rst_n empties the dictionary count, pending word
//   and full flag; memory contents are left as they are and never read
//   beyond the stored count.
module word_dictionary_tokenizer_core #(
  parameter int DICT_DEPTH = wdt_pkg::DICT_DEPTH_DEF,
  parameter int WORD_BYTES = wdt_pkg::WORD_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_opcode,
  input  logic [7:0]                in_char_byte,
  output logic                      out_valid,
  output logic                      out_result_kind,
  output logic [wdt_pkg::OUT_W-1:0] out_token_index,
  output logic                      out_found,
  output logic                      out_separator_kind,
  output logic [wdt_pkg::OUT_W-1:0] out_word_count,
  output logic                      out_dict_full
);
  localparam int AW = $clog2(DICT_DEPTH);
  localparam int CW = $clog2(DICT_DEPTH + 1);

  wdt_pkg::wdt_cmd_t cmd;
  wdt_pkg::wdt_sts_t sts;
  logic [AW-1:0]     rd_addr;
  logic [CW-1:0]     total;

  // Sequence the scan; advance one entry per cycle.
  wdt_ctrl #(.DICT_DEPTH(DICT_DEPTH)) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .opcode  (in_opcode),
    .sts     (sts),
    .total   (total),
    .busy    (busy),
    .rd_addr (rd_addr),
    .cmd     (cmd)
  );

  // Hold the word, the dictionary and the result registers.
  wdt_datapath #(.DICT_DEPTH(DICT_DEPTH), .WORD_BYTES(WORD_BYTES)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .opcode             (in_opcode),
    .char_byte          (in_char_byte),
    .rd_addr            (rd_addr),
    .sts                (sts),
    .total              (total),
    .out_valid          (out_valid),
    .out_result_kind    (out_result_kind),
    .out_token_index    (out_token_index),
    .out_found          (out_found),
    .out_separator_kind (out_separator_kind),
    .out_word_count     (out_word_count),
    .out_dict_full      (out_dict_full)
  );

  // A token result only follows a scan.
  a_token_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == wdt_pkg::KIND_TOKEN)) |-> $past(busy))
    else $error("token result without a scan");

  // A count result follows an accepted query.
  a_count_after_query: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == wdt_pkg::KIND_COUNT)) |->
      $past(start && !busy && (in_opcode == wdt_pkg::OP_QUERY)))
    else $error("count result without a query");

  // A miss carries no rank.
  a_miss_no_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == wdt_pkg::KIND_TOKEN) && !out_found) |->
      (out_token_index == '0))
    else $error("rank on a missed word");

  // Count never exceeds the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind == wdt_pkg::KIND_COUNT)) |->
      (32'(out_word_count) <= 32'(DICT_DEPTH)))
    else $error("word count beyond depth");
endmodule
